// ----- rtl/spab_pkg.sv -----
// ----------------------------------------------------------------------------
// spab_pkg: shared constants for the scaled partial-sum accumulator
// Field widths, register indexes and exponent thresholds used by the
// accumulator pipeline and its testbench.
// ----------------------------------------------------------------------------
package spab_pkg;

  localparam int MANTISSA_BITS  = 24;
  localparam int EXPONENT_BITS  = 8;
  localparam int EXTENSION_BITS = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FP8_PAIR_MODE    = 2'd0;
  localparam logic [1:0] CFG_BF16_OUTPUT_MODE = 2'd1;
  localparam logic [1:0] CFG_TENSOR_SCALE     = 2'd2;

  localparam logic [31:0] TENSOR_SCALE_RESET = 32'h3F80_0000;

  // Exponent thresholds for the bfloat16 packer.
  localparam logic signed [11:0] MAX_THRESH_FP8 = 12'sd388;
  localparam logic signed [11:0] MAX_THRESH_STD = 12'sd391;
  localparam logic signed [11:0] MIN_THRESH_FP8 = 12'sd134;
  localparam logic signed [11:0] MIN_THRESH_STD = 12'sd137;

  localparam logic [15:0] BF16_UPPER_FILL = 16'hFFFF;

endpackage

// ----- rtl/spab_if.sv -----
// ----------------------------------------------------------------------------
// spab_if: channel interfaces of the scaled partial-sum accumulator
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface spab_item_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  product_exponent;
  logic signed [23:0] product_mantissa;
  logic        [7:0]  activation_scale;
  logic        [7:0]  weight_scale;
  logic        [8:0]  psum_exponent;
  logic signed [22:0] psum_mantissa;

  modport source (output valid, product_exponent, product_mantissa, activation_scale,
                  weight_scale, psum_exponent, psum_mantissa, input ready);
  modport sink (input valid, product_exponent, product_mantissa, activation_scale,
                weight_scale, psum_exponent, psum_mantissa, output ready);
endinterface

interface spab_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] psum_word;

  modport source (output valid, psum_word, input ready);
  modport sink (input valid, psum_word, output ready);
endinterface

interface spab_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/scaled_psum_accumulate_bf16_top.sv -----
// ----------------------------------------------------------------------------
// scaled_psum_accumulate_bf16_top: scaled partial-sum accumulator
// Scales a product by block exponents, adds it to a partial sum and emits
// either the raw accumulator word or a scaled, rounded bfloat16 value.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries one product and one partial sum per transaction.
// The result channel returns exactly one psum_word per item, in order.
// The cfg channel writes fp8_pair_mode (index 0), bf16_output_mode (index 1)
// and tensor_scale (index 2); it is always ready and should only be used
// while no item is in flight. Other indexes are ignored.
// Throughput is one item per cycle while the receiver is ready; the five
// register stages (weight multiply, align and add, tensor-scale multiply,
// normalize, round and pack) each hold one item.
// When the receiver stalls, each stage holds its item and empty stages still
// fill, so the block keeps accepting until all five stages are occupied.
// Synchronous reset empties the pipeline and restores the register defaults
// (tensor_scale = 1.0). Nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module scaled_psum_accumulate_bf16_top (
  input logic          clk,
  input logic          rst,
  spab_item_if.sink    item,
  spab_result_if.source result,
  spab_cfg_if.sink     cfg
);
  import spab_pkg::*;

  // Configuration registers.
  logic        fp8_pair_mode;
  logic        bf16_output_mode;
  logic [31:0] tensor_scale;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fp8_pair_mode    <= 1'b0;
      bf16_output_mode <= 1'b0;
      tensor_scale     <= TENSOR_SCALE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FP8_PAIR_MODE:    fp8_pair_mode    <= cfg.data[0];
        CFG_BF16_OUTPUT_MODE: bf16_output_mode <= cfg.data[0];
        CFG_TENSOR_SCALE:     tensor_scale     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign item.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= item.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: decode the weight scale and apply it to the product.
  logic        [3:0]  wmat;
  logic        [7:0]  wexp;
  logic signed [28:0] wprod;
  logic        [9:0]  e1;
  logic signed [27:0] m1;
  logic        [8:0]  sexp1;
  logic signed [22:0] smat1;
  logic               empty1;

  always_comb begin
    if (fp8_pair_mode) begin
      wexp = item.weight_scale;
      wmat = 4'h8;
    end else begin
      wexp = {4'b0, item.weight_scale[6:3]};
      wmat = (item.weight_scale[6:3] != 4'd0) ? {1'b1, item.weight_scale[2:0]}
                                              : {item.weight_scale[2:0], 1'b0};
    end
    wprod = item.product_mantissa * $signed({1'b0, wmat});
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      e1     <= 10'(item.product_exponent) + 10'(item.activation_scale) + 10'(wexp);
      m1     <= wprod[27:0];
      sexp1  <= item.psum_exponent;
      smat1  <= item.psum_mantissa;
      empty1 <= (item.psum_exponent == 9'd0) && (item.psum_mantissa == 23'sd0);
    end
  end

  // Stage 2: align the smaller operand, add and renormalize on overflow; a zero partial sum passes the product through.
  logic signed [29:0] op_a, op_b, sum;
  logic        [9:0]  max_exp;
  logic               ovf;
  logic        [9:0]  ae2;
  logic signed [22:0] am2;

  always_comb begin
    op_a = 30'(m1);
    op_b = {smat1[22], smat1, 6'b0};
    if (e1 > {1'b0, sexp1}) begin
      op_b    = op_b >>> (e1 - {1'b0, sexp1});
      max_exp = e1;
    end else begin
      op_a    = op_a >>> ({1'b0, sexp1} - e1);
      max_exp = {1'b0, sexp1};
    end
    sum = op_a + op_b;
    ovf = sum[29] != sum[28];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      if (empty1) begin
        ae2 <= e1;
        am2 <= {m1[27], m1[27:6]};
      end else if (ovf) begin
        ae2 <= max_exp + 10'd1;
        am2 <= sum[29:7];
      end else begin
        ae2 <= max_exp;
        am2 <= sum[28:6];
      end
    end
  end

  // Stage 3: multiply by the per-tensor scale (1.0 in fp8 pair mode) and keep the raw word.
  logic        [7:0]  texp;
  logic        [23:0] tmat;
  logic signed [48:0] tprod;
  logic signed [23:0] sc3;
  logic        [10:0] ex3;
  logic        [31:0] raw3;

  always_comb begin
    if (fp8_pair_mode) begin
      texp = 8'd0;
      tmat = 24'h80_0000;
    end else begin
      texp = tensor_scale[30:23];
      tmat = (texp != 8'd0) ? {1'b1, tensor_scale[22:0]} : {tensor_scale[22:0], 1'b0};
    end
    tprod = am2 * $signed({1'b0, tmat});
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sc3  <= tprod[47:24];
      ex3  <= 11'(ae2) + 11'(texp);
      raw3 <= {ae2[8:0], am2};
    end
  end

  // Stage 4: magnitude, leading-zero count, normalize and range check.
  logic               sgn;
  logic        [22:0] mag, shifted;
  logic        [4:0]  lz;
  logic signed [11:0] adj, max_t, min_t, sh;
  logic        [22:0] bm4;
  logic        [7:0]  be4;
  logic               nrm4, sign4, zero4;
  logic        [31:0] raw4;

  always_comb begin
    sgn = sc3[23];
    mag = sgn ? (23'd0 - sc3[22:0]) : sc3[22:0];
    lz  = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (mag[i]) lz = 5'(22 - i);
    end
    shifted = mag << lz;
    adj   = $signed({1'b0, ex3}) + 12'sd8 - $signed({7'b0, lz});
    max_t = fp8_pair_mode ? MAX_THRESH_FP8 : MAX_THRESH_STD;
    min_t = fp8_pair_mode ? MIN_THRESH_FP8 : MIN_THRESH_STD;
    sh    = min_t - adj;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sign4 <= sgn;
      zero4 <= (mag == 23'd0);
      raw4  <= raw3;
      if (adj > max_t) begin
        be4  <= 8'hFF;
        bm4  <= 23'd0;
        nrm4 <= 1'b0;
      end else if (adj <= min_t) begin
        be4  <= 8'd0;
        bm4  <= shifted >> sh[7:0];
        nrm4 <= 1'b0;
      end else begin
        be4  <= 8'(adj - min_t);
        bm4  <= shifted;
        nrm4 <= 1'b1;
      end
    end
  end

  // Stage 5: round to nearest even, pack and register the result.
  logic        guard, sticky, lsb;
  logic [6:0]  m7;
  logic [7:0]  rounded;
  logic [8:0]  exp_sum;
  logic [7:0]  out_exp;
  logic [6:0]  out_frac;
  logic [15:0] bf;
  logic [31:0] psum_word;

  always_comb begin
    if (nrm4) begin
      guard  = bm4[14];
      sticky = |bm4[13:0];
      lsb    = bm4[15];
      m7     = bm4[21:15];
    end else begin
      guard  = bm4[15];
      sticky = |bm4[14:0];
      lsb    = bm4[16];
      m7     = bm4[22:16];
    end
    rounded = {1'b0, m7} + {7'b0, guard && (sticky || lsb)};
    exp_sum = {1'b0, be4} + {8'b0, rounded[7]};
    if (exp_sum > 9'd254) begin
      out_exp  = 8'hFF;
      out_frac = 7'd0;
    end else begin
      out_exp = exp_sum[7:0];
      if (rounded[7]) out_frac = {!nrm4, rounded[6:1]};
      else            out_frac = rounded[6:0];
    end
    bf = zero4 ? {sign4, 15'd0} : {sign4, out_exp, out_frac};
  end

  always_ff @(posedge clk) begin
    if (en5) psum_word <= bf16_output_mode ? {BF16_UPPER_FILL, bf} : raw4;
  end

  assign result.valid     = v5;
  assign result.psum_word = psum_word;

endmodule

// ----- rtl/spab_checker.sv -----
// ----------------------------------------------------------------------------
// spab_checker: port-level checks for the scaled partial-sum accumulator
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module spab_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data,
  input logic        cfg_ready
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The configuration channel never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> cfg_ready)
    else $error("configuration channel not ready");

  // An accepted item reaches the output when the receiver keeps up and no reset intervenes.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(in_valid && in_ready, 5) && $past(out_ready, 1) && $past(out_ready, 2) &&
    $past(out_ready, 3) && $past(out_ready, 4) && !$past(rst, 1) && !$past(rst, 2) &&
    !$past(rst, 3) && !$past(rst, 4) && !$past(rst, 5) |-> out_valid)
    else $error("accepted transaction did not reach the output in five cycles");

endmodule

bind scaled_psum_accumulate_bf16_top spab_checker u_spab_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.psum_word),
  .cfg_ready (cfg.ready)
);

// ----- test/spab_checker.sv -----
// ----------------------------------------------------------------------------
// spab_scoreboard: result predictor and scoreboard for the partial-sum accumulator
// Watches the item, result and configuration channels, computes the expected
// psum_word for every accepted item and compares results in order.
// ----------------------------------------------------------------------------
module spab_scoreboard
  import spab_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  spab_item_if.sink     item,
  spab_result_if.sink   result,
  spab_cfg_if.sink      cfg,
  output int            fail_count,
  output int            pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        pair_mode;
  logic        bf16_mode;
  logic [31:0] tscale;
  logic [31:0] expected_words[$];

  // Arithmetic shift right on a 64-bit word, saturating at 64.
  function automatic logic [63:0] shift_signed(logic [63:0] x, int unsigned n);
    if (n >= 64) return x[63] ? '1 : '0;
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] widen(logic [63:0] x, int w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    x &= m;
    if (x[w-1]) x |= ~m;
    return x;
  endfunction

  // Normalize, round to nearest even and pack as bfloat16.
  function automatic logic [15:0] pack_bf16(logic [31:0] ex, logic [63:0] mat, logic fp8);
    logic        sgn;
    logic [63:0] mag, shifted, bmat;
    int          lz, adj, maxt, mint, sh, gpos;
    logic [31:0] bexp, rnd, oexp, ofrac;
    logic        normal, guard, sticky, lsb;
    sgn = mat[MANTISSA_BITS-1];
    mag = mat & ((64'd1 << (MANTISSA_BITS-1)) - 1);
    if (sgn) mag = (-mag) & ((64'd1 << (MANTISSA_BITS-1)) - 1);
    if (mag == 0) return {sgn, 15'd0};
    lz = 0;
    for (int i = MANTISSA_BITS-2; i >= 0; i--) begin
      if (mag[i]) break;
      lz++;
    end
    shifted = mag << lz;
    adj = int'(ex) + EXTENSION_BITS - lz;
    maxt = fp8 ? int'(MAX_THRESH_FP8) : int'(MAX_THRESH_STD);
    mint = fp8 ? int'(MIN_THRESH_FP8) : int'(MIN_THRESH_STD);
    if (adj > maxt) begin
      bexp = 32'hFF; bmat = '0; normal = 1'b0;
    end else if (adj <= mint) begin
      sh = mint - adj;
      bexp = '0; bmat = (sh >= 64) ? 64'd0 : (shifted >> sh); normal = 1'b0;
    end else begin
      bexp = 32'(adj - mint) & 32'hFF; bmat = shifted; normal = 1'b1;
    end
    gpos = normal ? MANTISSA_BITS-10 : MANTISSA_BITS-9;
    guard = bmat[gpos];
    sticky = (bmat & ((64'd1 << gpos) - 1)) != 0;
    lsb = bmat[gpos+1];
    rnd = 32'((bmat >> (gpos+1)) & 64'h7F) + 32'(guard && (sticky || lsb));
    if (bexp + 32'(rnd[7]) > 254) begin
      oexp = 32'hFF; ofrac = '0;
    end else begin
      oexp = (bexp + 32'(rnd[7])) & 32'hFF;
      if (rnd[7]) ofrac = normal ? ((rnd >> 1) & 32'h3F) : (32'h40 | ((rnd >> 1) & 32'h3F));
      else ofrac = rnd & 32'h7F;
    end
    return {sgn, oexp[7:0], ofrac[6:0]};
  endfunction

  // Expected psum_word for one item under the current register values.
  function automatic logic [31:0] accumulate_word(logic [7:0] pexp, logic [23:0] pmat,
      logic [7:0] ascale, logic [7:0] wscale, logic [8:0] sexp, logic [22:0] smat);
    logic [31:0] wexp, wmat, pe, acc_exp, texp;
    logic [63:0] pm, acc_mat, a, b, sum, tmat, scaled;
    if (pair_mode) begin
      wexp = 32'(wscale); wmat = 32'd8;
    end else begin
      wexp = 32'(wscale[6:3]);
      wmat = (wexp != 0) ? (32'd8 | 32'(wscale[2:0])) : 32'({wscale[2:0], 1'b0});
    end
    pe = 32'(pexp) + 32'(ascale) + wexp;
    pm = widen(64'(pmat), MANTISSA_BITS) * 64'(wmat);
    if (sexp == 0 && smat == 0) begin
      acc_exp = pe;
      acc_mat = widen(shift_signed(pm, 6), MANTISSA_BITS-1);
    end else begin
      a = pm;
      b = widen(64'(smat), MANTISSA_BITS-1) << 6;
      if (pe > 32'(sexp)) begin
        b = shift_signed(b, pe - 32'(sexp)); acc_exp = pe;
      end else begin
        a = shift_signed(a, 32'(sexp) - pe); acc_exp = 32'(sexp);
      end
      sum = a + b;
      if (sum[MANTISSA_BITS+5] != sum[MANTISSA_BITS+4]) begin
        acc_mat = shift_signed(sum, 7); acc_exp++;
      end else begin
        acc_mat = widen(shift_signed(sum, 6), MANTISSA_BITS-1);
      end
    end
    if (bf16_mode) begin
      if (pair_mode) begin
        texp = '0; tmat = 64'h80_0000;
      end else begin
        texp = 32'(tscale[30:23]);
        tmat = (texp != 0) ? 64'({1'b1, tscale[22:0]}) : 64'({tscale[22:0], 1'b0});
      end
      scaled = widen((acc_mat * tmat) >> 24, MANTISSA_BITS);
      return {BF16_UPPER_FILL, pack_bf16(acc_exp + texp, scaled, pair_mode)};
    end
    return {acc_exp[EXPONENT_BITS:0], acc_mat[MANTISSA_BITS-2:0]};
  endfunction

  assign pending_words = expected_words.size();

  // Track registers, predict accepted items and check results.
  always @(posedge clk) begin
    if (rst) begin
      pair_mode <= 1'b0;
      bf16_mode <= 1'b0;
      tscale <= TENSOR_SCALE_RESET;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected psum_word %h", $time, result.psum_word);
          fail_count <= fail_count + 1;
        end else if (expected_words[0] !== result.psum_word) begin
          $display("%0t: psum_word expected %h actual %h", $time, expected_words[0],
                   result.psum_word);
          fail_count <= fail_count + 1;
          void'(expected_words.pop_front());
        end else begin
          void'(expected_words.pop_front());
        end
      end
      if (item.valid && item.ready)
        expected_words.push_back(accumulate_word(item.product_exponent,
            item.product_mantissa, item.activation_scale, item.weight_scale,
            item.psum_exponent, item.psum_mantissa));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FP8_PAIR_MODE: begin
            pair_mode <= cfg.data[0];
          end
          CFG_BF16_OUTPUT_MODE: begin
            bf16_mode <= cfg.data[0];
          end
          CFG_TENSOR_SCALE: begin
            tscale <= cfg.data;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

// ----- test/scaled_psum_accumulate_bf16_top_tb.sv -----
// ----------------------------------------------------------------------------
// scaled_psum_accumulate_bf16_top_tb: accumulator testbench
// Runs directed corner items and random items across several register
// settings with random idling on both channels; a checker compares results.
// ----------------------------------------------------------------------------
module scaled_psum_accumulate_bf16_top_tb;
  import spab_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_words;
  int   cycle_count = 0;
  logic calm = 1'b0;
  int   sink_burst = 0;

  spab_item_if   item();
  spab_result_if result();
  spab_cfg_if    cfg();

  scaled_psum_accumulate_bf16_top uut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  spab_scoreboard checker_i (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.sink), .cfg(cfg.sink),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always #1 clk = ~clk;

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (sink_burst > 0) begin
      sink_burst <= sink_burst - 1;
      result.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_burst <= $urandom_range(0, 15);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  initial begin
    item.valid = 1'b0;
    item.product_exponent = '0;
    item.product_mantissa = '0;
    item.activation_scale = '0;
    item.weight_scale = '0;
    item.psum_exponent = '0;
    item.psum_mantissa = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_FP8_PAIR_MODE;
    cfg.data = '0;
  end

  // Write one register and wait for the transaction, then drop valid and idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one item, with an optional sender gap first.
  task automatic send_item(logic [7:0] pe, logic [23:0] pm, logic [7:0] sa,
                           logic [7:0] ws, logic [8:0] se, logic [22:0] sm);
    if (!calm && $urandom_range(0, 6) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.product_exponent <= pe;
    item.product_mantissa <= pm;
    item.activation_scale <= sa;
    item.weight_scale <= ws;
    item.psum_exponent <= se;
    item.psum_mantissa <= sm;
    do @(posedge clk); while (!item.ready);
  endtask

  // Drop valid so the last accepted item is counted, then wait until no result is pending.
  task automatic drain_results();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random item; exponents mostly close together so sums really align.
  task automatic send_random();
    logic [7:0] pe;
    logic [8:0] se;
    logic [23:0] pm;
    logic [22:0] sm;
    pe = 8'($urandom);
    pm = 24'($urandom);
    sm = 23'($urandom);
    case ($urandom_range(0, 9))
      0: se = '0;
      1: se = 9'($urandom);
      default: se = 9'(int'(pe) + int'($urandom_range(0, 200)) - 20);
    endcase
    if ($urandom_range(0, 9) == 0) sm = '0;
    if ($urandom_range(0, 9) == 0) pm = 24'($urandom_range(0, 3) << $urandom_range(0, 22));
    send_item(pe, pm, 8'($urandom_range(0, 40)), 8'($urandom), se, sm);
  endtask

  initial begin
    logic [31:0] scales[6];
    scales = '{TENSOR_SCALE_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h007F_FFFF,
               32'h4123_4567, 32'h0E80_0001};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners in raw mode at reset settings.
    send_item(8'h00, 24'h00_0000, 8'h00, 8'h00, 9'h000, 23'h00_0000);
    send_item(8'hFF, 24'h7F_FFFF, 8'hFF, 8'hFF, 9'h1FF, 23'h3F_FFFF);
    send_item(8'hFF, 24'h80_0000, 8'hFF, 8'h7F, 9'h000, 23'h00_0000);
    send_item(8'h10, 24'h7F_FFFF, 8'h00, 8'h08, 9'h018, 23'h3F_FFFF);
    send_item(8'h10, 24'h80_0000, 8'h00, 8'h08, 9'h018, 23'h40_0000);
    send_item(8'h00, 24'h12_3456, 8'h00, 8'h05, 9'h1FF, 23'h00_0001);
    send_item(8'hFF, 24'h00_0001, 8'hFF, 8'h78, 9'h001, 23'h7F_FFFF);
    send_item(8'h80, 24'h40_0000, 8'h00, 8'h08, 9'h080, 23'h20_0000);

    // Phases cycling through output modes, pair mode and tensor scales.
    for (int ph = 0; ph < 12; ph++) begin
      drain_results();
      write_reg(CFG_FP8_PAIR_MODE, 32'(ph % 2));
      write_reg(CFG_BF16_OUTPUT_MODE, 32'((ph / 2) % 3 != 0));
      write_reg(CFG_TENSOR_SCALE, scales[ph % 6]);
      if (ph == 11) calm = 1'b1;
      // Directed bf16 corners: zero, tiny, huge, rounding edges.
      send_item(8'h00, 24'h00_0000, 8'h00, 8'h00, 9'h000, 23'h00_0000);
      send_item(8'h00, 24'h80_0000, 8'h00, 8'h00, 9'h000, 23'h00_0000);
      send_item(8'hFF, 24'h7F_FFFF, 8'hFF, 8'hFF, 9'h000, 23'h00_0000);
      send_item(8'h60, 24'h01_FFFF, 8'h10, 8'h38, 9'h000, 23'h00_0000);
      send_item(8'h02, 24'h7F_FF80, 8'h00, 8'h08, 9'h000, 23'h00_0000);
      send_item(8'h78, 24'hFF_FFFF, 8'h00, 8'h0F, 9'h000, 23'h00_0000);
      for (int n = 0; n < 130; n++) send_random();
    end
    drain_results();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
